// ===== src/idp_pkg.sv =====
// Shared types, constants and microcode ROM of the integer digit and prime unit.
package idp_pkg;

  localparam int NUMBER_WIDTH_DEF = 16;
  localparam int VALUE_W          = 17;
  localparam int VERDICT_W        = 2;
  localparam int MODE_W           = 3;
  localparam int UPC_W            = 4;
  localparam int DIGIT_W          = 4;
  localparam int DIGIT_BASE       = 10;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every n below 2^32
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // modes
  localparam logic [MODE_W-1:0] MODE_PARITY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRIME  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PAL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SIGN   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REV    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SUM    = 3'd5;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_NO   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_YES  = 2'd1;
  localparam logic [VERDICT_W-1:0] SIGN_POS     = 2'd0;
  localparam logic [VERDICT_W-1:0] SIGN_NEG     = 2'd1;
  localparam logic [VERDICT_W-1:0] SIGN_ZERO    = 2'd2;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SET_PARITY,
    OP_SET_SIGN,
    OP_PRIME_INIT,
    OP_DIV_DSR,
    OP_DIV_TEN,
    OP_TEN_REM,
    OP_PRIME_NEXT,
    OP_SET_YES,
    OP_DIGIT,
    OP_DIGIT_END,
    OP_FINISH
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_LT2,
    COND_SQ_GT_N,
    COND_DIV_BUSY,
    COND_REM_ZERO,
    COND_N_ZERO,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  // program step addresses
  localparam upc_t STEP_PARITY  = 4'd0;
  localparam upc_t STEP_SIGN    = 4'd1;
  localparam upc_t STEP_PRIME   = 4'd2;
  localparam upc_t STEP_PLOOP   = 4'd3;
  localparam upc_t STEP_PDIV    = 4'd4;
  localparam upc_t STEP_PWAIT   = 4'd5;
  localparam upc_t STEP_PTEST   = 4'd6;
  localparam upc_t STEP_PNEXT   = 4'd7;
  localparam upc_t STEP_PYES    = 4'd8;
  localparam upc_t STEP_DIGITS  = 4'd9;
  localparam upc_t STEP_DDIV    = 4'd10;
  localparam upc_t STEP_DREM    = 4'd11;
  localparam upc_t STEP_DACC    = 4'd12;
  localparam upc_t STEP_DEND    = 4'd13;
  localparam upc_t STEP_FINISH  = 4'd14;

  function automatic ctrl_word_t ucode_rom(input upc_t upc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_FINISH};
    case (upc)
      STEP_PARITY: w = '{op: OP_SET_PARITY, cond: COND_ALWAYS,   target: STEP_FINISH};
      STEP_SIGN:   w = '{op: OP_SET_SIGN,   cond: COND_ALWAYS,   target: STEP_FINISH};
      STEP_PRIME:  w = '{op: OP_PRIME_INIT, cond: COND_LT2,      target: STEP_FINISH};
      STEP_PLOOP:  w = '{op: OP_NOP,        cond: COND_SQ_GT_N,  target: STEP_PYES};
      STEP_PDIV:   w = '{op: OP_DIV_DSR,    cond: COND_NEXT,     target: STEP_PWAIT};
      STEP_PWAIT:  w = '{op: OP_NOP,        cond: COND_DIV_BUSY, target: STEP_PWAIT};
      STEP_PTEST:  w = '{op: OP_NOP,        cond: COND_REM_ZERO, target: STEP_FINISH};
      STEP_PNEXT:  w = '{op: OP_PRIME_NEXT, cond: COND_ALWAYS,   target: STEP_PLOOP};
      STEP_PYES:   w = '{op: OP_SET_YES,    cond: COND_ALWAYS,   target: STEP_FINISH};
      STEP_DIGITS: w = '{op: OP_NOP,        cond: COND_N_ZERO,   target: STEP_DEND};
      STEP_DDIV:   w = '{op: OP_DIV_TEN,    cond: COND_NEXT,     target: STEP_DREM};
      STEP_DREM:   w = '{op: OP_TEN_REM,    cond: COND_NEXT,     target: STEP_DACC};
      STEP_DACC:   w = '{op: OP_DIGIT,      cond: COND_ALWAYS,   target: STEP_DIGITS};
      STEP_DEND:   w = '{op: OP_DIGIT_END,  cond: COND_ALWAYS,   target: STEP_FINISH};
      STEP_FINISH: w = '{op: OP_FINISH,     cond: COND_OUT_FULL, target: STEP_FINISH};
      default:     w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: STEP_FINISH};
    endcase
    return w;
  endfunction

  // first program step for each mode; unused modes go straight to the result
  function automatic upc_t mode_entry(input logic [MODE_W-1:0] mode);
    upc_t e;
    case (mode) inside
      MODE_PARITY:                  e = STEP_PARITY;
      MODE_SIGN:                    e = STEP_SIGN;
      MODE_PRIME:                   e = STEP_PRIME;
      MODE_PAL, MODE_REV, MODE_SUM: e = STEP_DIGITS;
      default:                      e = STEP_FINISH;
    endcase
    return e;
  endfunction

endpackage

// ===== src/idp_in_if.sv =====
// Input channel interface: mode and operand with valid/ready.
interface idp_in_if
  import idp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic [MODE_W-1:0]              mode;
  logic signed [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output mode, output number, input ready);
  modport sink   (input valid, input mode, input number, output ready);
endinterface

// ===== src/idp_out_if.sv =====
// Result channel interface: verdict and value with valid/ready.
interface idp_out_if
  import idp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output verdict, output value, input ready);
  modport sink   (input valid, input verdict, input value, output ready);
endinterface

// ===== src/idp_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module idp_div
  import idp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output logic                    busy,
  output logic [NUMBER_WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

  logic                    busy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [NUMBER_WIDTH-1:0] quot_r;
  logic [NUMBER_WIDTH-1:0] rem_r;
  logic [NUMBER_WIDTH-1:0] dsr_r;
  logic [NUMBER_WIDTH:0]   shifted;
  logic [NUMBER_WIDTH:0]   diff;
  logic                    fits;

  assign shifted = {rem_r, quot_r[NUMBER_WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= CNT_W'(NUMBER_WIDTH);
      quot_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (fits) begin
        rem_r  <= diff[NUMBER_WIDTH-1:0];
        quot_r <= {quot_r[NUMBER_WIDTH-2:0], 1'b1};
      end else begin
        rem_r  <= shifted[NUMBER_WIDTH-1:0];
        quot_r <= {quot_r[NUMBER_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== src/integer_digit_and_prime_unit_core.sv =====
// Top level: microcoded parity / prime / palindrome / sign / reverse / digit-sum unit.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        mode[2:0], number[NUMBER_WIDTH-1:0] signed
//   out_ch   out  valid/ready        verdict[1:0], value[16:0]
//
// The divide by ten in the digit modes is a reciprocal multiply, the remainder a
// shift-and-subtract. Prime mode tries divisors d while d*d <= number on the
// restoring divider; a 16-bit prime near the top tries about 180 divisors.
// Reset (rst_n low, synchronous) idles the sequencer and drops out_ch.valid.
// in_ch.ready is high whenever no transaction is being worked on, even while a
// finished result waits in the output register; a stalled output holds the
// sequencer on its last step until the register frees up.
module integer_digit_and_prime_unit_core
  import idp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  idp_in_if.sink    in_ch,
  idp_out_if.source out_ch
);

  localparam int CMP_W = (NUMBER_WIDTH > VALUE_W) ? NUMBER_WIDTH : VALUE_W;
  localparam int EXT_W = CMP_W + 4;
  localparam logic [CMP_W-1:0] ACC_MAX = {CMP_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  upc_t   upc_r, upc_nxt;

  // working registers
  logic [MODE_W-1:0]       mode_r;
  logic [NUMBER_WIDTH-1:0] raw_r;     // operand as received
  logic                    neg_r;
  logic [NUMBER_WIDTH-1:0] n_r;       // operand if non-negative, else zero; shrinks in digit modes
  logic [NUMBER_WIDTH-1:0] d_r;       // trial divisor
  logic [NUMBER_WIDTH:0]   sq_r;      // d_r squared
  logic [NUMBER_WIDTH-1:0] q10_r;     // n_r / 10
  logic [DIGIT_W-1:0]      digit_r;   // n_r % 10
  logic [CMP_W-1:0]        acc_r;     // reversal or digit sum
  logic                    ovf_r;     // reversal exceeds the accumulator
  logic [VERDICT_W-1:0]    verdict_r;
  logic [VALUE_W-1:0]      value_r;

  // output register
  logic                    out_valid_r;
  logic [VERDICT_W-1:0]    out_verdict_r;
  logic [VALUE_W-1:0]      out_value_r;

  ctrl_word_t              ctrl;
  logic                    run;
  logic                    accept;
  logic                    cond_true;
  logic                    finish_fire;
  logic                    div_start;
  logic                    div_busy;
  logic [NUMBER_WIDTH-1:0] div_rem;
  logic [NUMBER_WIDTH+31:0] ten_prod;
  logic [NUMBER_WIDTH-1:0] ten_rem;
  logic [EXT_W-1:0]        rev_ext;
  logic                    pal_match;

  assign run    = (state_r == ST_RUN);
  assign accept = in_ch.valid && in_ch.ready;
  assign ctrl   = ucode_rom(upc_r);

  assign in_ch.ready = (state_r == ST_IDLE);

  // ---- divider: trial divisor in prime mode ----
  assign div_start = run && (ctrl.op == OP_DIV_DSR);

  idp_div #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // ---- divide by ten: reciprocal multiply, then n - 8q - 2q ----
  assign ten_prod = {32'd0, n_r} * {{NUMBER_WIDTH{1'b0}}, RECIP_TEN};
  assign ten_rem  = n_r - (q10_r << 3) - (q10_r << 1);

  // ---- jump condition ----
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_LT2:      cond_true = (n_r < NUMBER_WIDTH'(2));
      COND_SQ_GT_N:  cond_true = (sq_r > {1'b0, n_r});
      COND_DIV_BUSY: cond_true = div_busy;
      COND_REM_ZERO: cond_true = (div_rem == '0);
      COND_N_ZERO:   cond_true = (n_r == '0);
      COND_OUT_FULL: cond_true = out_valid_r && !out_ch.ready;
      default:       cond_true = 1'b0;
    endcase
  end

  assign finish_fire = run && (ctrl.op == OP_FINISH) && !cond_true;

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    if (accept) begin
      state_nxt = ST_RUN;
      upc_nxt   = mode_entry(in_ch.mode);
    end else if (finish_fire) begin
      state_nxt = ST_IDLE;
    end else if (run) begin
      upc_nxt = cond_true ? ctrl.target : upc_r + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      upc_r   <= STEP_FINISH;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
    end
  end

  // ---- datapath ----
  assign rev_ext   = (EXT_W'(acc_r) << 3) + (EXT_W'(acc_r) << 1) + EXT_W'(digit_r);
  // a palindrome's reversal fits the operand, so an overflowed one never matches
  assign pal_match = !ovf_r && !neg_r && (acc_r == CMP_W'(raw_r));

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_ch.mode;
      raw_r     <= in_ch.number;
      neg_r     <= in_ch.number[NUMBER_WIDTH-1];
      n_r       <= in_ch.number[NUMBER_WIDTH-1] ? '0 : in_ch.number;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      verdict_r <= VERDICT_NO;
      value_r   <= '0;
    end else if (run) begin
      case (ctrl.op)
        OP_SET_PARITY: verdict_r <= {1'b0, raw_r[0]};
        OP_SET_SIGN: begin
          if (neg_r) begin
            verdict_r <= SIGN_NEG;
          end else if (raw_r == '0) begin
            verdict_r <= SIGN_ZERO;
          end else begin
            verdict_r <= SIGN_POS;
          end
        end
        OP_PRIME_INIT: begin
          d_r  <= NUMBER_WIDTH'(2);
          sq_r <= (NUMBER_WIDTH + 1)'(4);
        end
        OP_PRIME_NEXT: begin
          // (d+1)^2 = d^2 + 2d + 1
          d_r  <= d_r + NUMBER_WIDTH'(1);
          sq_r <= sq_r + {d_r, 1'b1};
        end
        OP_SET_YES: verdict_r <= VERDICT_YES;
        OP_DIV_TEN: q10_r <= NUMBER_WIDTH'(ten_prod[NUMBER_WIDTH+31:RECIP_SHIFT]);
        OP_TEN_REM: digit_r <= ten_rem[DIGIT_W-1:0];
        OP_DIGIT: begin
          n_r <= q10_r;
          if (mode_r == MODE_SUM) begin
            acc_r <= acc_r + CMP_W'(digit_r);
          end else if (ovf_r || rev_ext > EXT_W'(ACC_MAX)) begin
            acc_r <= ACC_MAX;
            ovf_r <= 1'b1;
          end else begin
            acc_r <= rev_ext[CMP_W-1:0];
          end
        end
        OP_DIGIT_END: begin
          if (mode_r == MODE_PAL) begin
            verdict_r <= pal_match ? VERDICT_YES : VERDICT_NO;
          end else if (ovf_r || acc_r > CMP_W'(VALUE_MAX)) begin
            value_r <= VALUE_MAX;
          end else begin
            value_r <= acc_r[VALUE_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_verdict_r <= verdict_r;
      out_value_r   <= value_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = out_verdict_r;
  assign out_ch.value   = out_value_r;

  // ---- assertions ----
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_RUN)
    else $error("sequencer did not start after input transaction");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    finish_fire |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished transaction not presented");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> acc_r == ACC_MAX)
    else $error("reversal overflow without saturation");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for integer_digit_and_prime_unit_core: table-driven and random checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idp_pkg::*;

  localparam int NW             = NUMBER_WIDTH_DEF;
  localparam int NUM_RANDOM     = 75;
  // Prime mode is the slowest path; the watchdog limit leaves room for it and for
  // stalls on both sides.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int MAX_REPORTS    = 10;

  // modes the block does not define; both must yield an all-zero result
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [VALUE_W-1:0]   value;
  } result_t;

  // one directed row: when typed is set the expected result is taken from the
  // row, otherwise from the predictor
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic signed [NW-1:0] number;
    logic                 typed;
    logic [VERDICT_W-1:0] verdict;
    logic [VALUE_W-1:0]   value;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam stim_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
    // parity: extremes and a negative odd number
    '{MODE_PARITY,   16'sd0,      1'b1, VERDICT_NO,  17'd0},
    '{MODE_PARITY,   16'sd32767,  1'b1, VERDICT_YES, 17'd0},
    '{MODE_PARITY,   -16'sd32768, 1'b1, VERDICT_NO,  17'd0},
    '{MODE_PARITY,   -16'sd3,     1'b1, VERDICT_YES, 17'd0},
    // prime: below two, the two smallest primes, and the top of the range
    '{MODE_PRIME,    -16'sd32768, 1'b1, VERDICT_NO,  17'd0},
    '{MODE_PRIME,    16'sd0,      1'b1, VERDICT_NO,  17'd0},
    '{MODE_PRIME,    16'sd1,      1'b1, VERDICT_NO,  17'd0},
    '{MODE_PRIME,    16'sd2,      1'b1, VERDICT_YES, 17'd0},
    '{MODE_PRIME,    16'sd3,      1'b1, VERDICT_YES, 17'd0},
    '{MODE_PRIME,    16'sd32749,  1'b0, VERDICT_NO,  17'd0},
    '{MODE_PRIME,    16'sd32767,  1'b0, VERDICT_NO,  17'd0},
    // palindrome: zero is one, negatives never are
    '{MODE_PAL,      16'sd0,      1'b1, VERDICT_YES, 17'd0},
    '{MODE_PAL,      -16'sd121,   1'b1, VERDICT_NO,  17'd0},
    '{MODE_PAL,      16'sd12321,  1'b0, VERDICT_NO,  17'd0},
    // sign classes
    '{MODE_SIGN,     16'sd0,      1'b1, SIGN_ZERO,   17'd0},
    '{MODE_SIGN,     -16'sd1,     1'b1, SIGN_NEG,    17'd0},
    '{MODE_SIGN,     16'sd32767,  1'b1, SIGN_POS,    17'd0},
    '{MODE_SIGN,     -16'sd32768, 1'b1, SIGN_NEG,    17'd0},
    // reversal: largest operand, negative operand, trailing zeros
    '{MODE_REV,      16'sd32767,  1'b1, VERDICT_NO,  17'd76723},
    '{MODE_REV,      -16'sd5,     1'b1, VERDICT_NO,  17'd0},
    '{MODE_REV,      16'sd10000,  1'b0, VERDICT_NO,  17'd0},
    // digit sum
    '{MODE_SUM,      16'sd32767,  1'b1, VERDICT_NO,  17'd25},
    '{MODE_SUM,      -16'sd32768, 1'b1, VERDICT_NO,  17'd0},
    // undefined modes
    '{MODE_UNUSED_6, -16'sd1,     1'b1, VERDICT_NO,  17'd0},
    '{MODE_UNUSED_7, 16'sd12345,  1'b1, VERDICT_NO,  17'd0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  idp_in_if #(.NUMBER_WIDTH(NW)) in_ch ();
  idp_out_if                     out_ch ();

  integer_digit_and_prime_unit_core #(.NUMBER_WIDTH(NW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  result_t expected_results[$];
  int      mismatches  = 0;
  int      idle_cycles = 0;
  int      out_stall   = 0;
  bit      calm        = 1'b0;  // set: neither side idles

  // Gap length in cycles: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Expected result of one transaction, computed from the operand alone.
  function automatic result_t predict_result(input logic [MODE_W-1:0] mode,
                                             input logic signed [NW-1:0] number);
    result_t res;
    int      mag;
    int      n;
    int      rev;
    int      sum;
    int      d;
    bit      prime;
    res = '0;
    // digit and prime modes only look at positive operands
    mag = (number < 0) ? 0 : int'(number);
    rev = 0;
    sum = 0;
    n   = mag;
    while (n > 0) begin
      rev = rev * 10 + n % 10;
      sum = sum + n % 10;
      n   = n / 10;
    end
    // trial division; stopping at d*d > mag decides the same as stopping at mag/2
    prime = (mag >= 2);
    d     = 2;
    while (prime && d * d <= mag) begin
      if (mag % d == 0) prime = 1'b0;
      d++;
    end
    case (mode)
      MODE_PARITY: res.verdict = {1'b0, number[0]};
      MODE_PRIME:  res.verdict = prime ? VERDICT_YES : VERDICT_NO;
      MODE_PAL:    res.verdict = (number >= 0 && rev == mag) ? VERDICT_YES : VERDICT_NO;
      MODE_SIGN: begin
        if (number < 0)       res.verdict = SIGN_NEG;
        else if (number == 0) res.verdict = SIGN_ZERO;
        else                  res.verdict = SIGN_POS;
      end
      MODE_REV:    res.value = (rev > int'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(rev);
      MODE_SUM:    res.value = VALUE_W'(sum);
      default:     res = '0;
    endcase
    return res;
  endfunction

  // 3-digit (ab -> aba) or 5-digit (abc -> abcba) decimal palindrome
  function automatic logic signed [NW-1:0] make_palindrome();
    int h;
    if ($urandom_range(0, 1) == 0) begin
      h = $urandom_range(10, 99);
      return NW'(h * 10 + h / 10);
    end
    h = $urandom_range(100, 327);
    return NW'(h * 100 + ((h / 10) % 10) * 10 + h / 100);
  endfunction

  function automatic logic signed [NW-1:0] pick_number();
    case ($urandom_range(0, 5))
      0, 1:    return NW'($urandom_range(0, 65535));  // full range, every bit
      2:       return NW'($urandom_range(0, 200));
      3:       return -NW'($urandom_range(1, 60));
      4:       return make_palindrome();
      default: return ($urandom_range(0, 1) == 0) ? NW'(32767 - $urandom_range(0, 30))
                                                   : NW'(-32768 + $urandom_range(0, 30));
    endcase
  endfunction

  // Drives one input transaction. valid stays high across back-to-back
  // transactions and is lowered only when a gap is inserted.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic signed [NW-1:0] number,
                           input bit typed, input result_t want);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid  <= 1'b0;
      in_ch.mode   <= MODE_W'($urandom);   // junk payload while idle
      in_ch.number <= NW'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.number <= number;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(typed ? want : predict_result(mode, number));
  endtask

  // Result side: compare each accepted transaction with the oldest expectation,
  // then decide ready for the next cycle.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: verdict=%0d value=%0d", out_ch.verdict, out_ch.value);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.verdict !== want.verdict || out_ch.value !== want.value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: verdict exp %0d got %0d, value exp %0d got %0d",
                       want.verdict, out_ch.verdict, want.value, out_ch.value);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_stall = pick_gap();
        out_ch.ready <= (out_stall == 0);
        if (out_stall > 0) out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [MODE_W-1:0] mode;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_PARITY;
    in_ch.number = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].mode, DIRECTED[i].number, DIRECTED[i].typed,
                '{verdict: DIRECTED[i].verdict, value: DIRECTED[i].value});

    // random transactions; a stretch in the middle runs with no idling
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 40 && i < 60);
      mode = MODE_W'($urandom_range(0, 7));
      send_item(mode, pick_number(), 1'b0, '0);
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // catch any stray result beyond the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== integer_digit_and_prime_unit_core.f =====
src/idp_pkg.sv
src/idp_in_if.sv
src/idp_out_if.sv
src/idp_div.sv
src/integer_digit_and_prime_unit_core.sv
tb/tb.sv
